// ===== rtl/core/lsfs_pkg.sv =====
// Package: shared types and constants for the LED string frame serializer.
package lsfs_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int SLOT_CNT_W  = $clog2(MAX_SLOTS);
    localparam int SLOT_LIM_W  = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W       = 7;
    localparam int CFG_RESET   = 24;
    localparam int COLOR_W     = 32;
    localparam int BYTE_IDX_W  = 5;
    localparam int BIT_IDX_W   = 5;

    localparam logic [BYTE_IDX_W-1:0] IDX_HDR0      = 5'd0;
    localparam logic [BYTE_IDX_W-1:0] IDX_HDR1      = 5'd1;
    localparam logic [BYTE_IDX_W-1:0] IDX_DATA0     = 5'd2;
    localparam logic [BYTE_IDX_W-1:0] IDX_DATA_LAST = 5'd17;
    localparam logic [BYTE_IDX_W-1:0] IDX_TRL0      = 5'd18;
    localparam logic [BYTE_IDX_W-1:0] IDX_TRL1      = 5'd19;

    localparam logic [7:0] HDR0_BYTE = 8'h00;
    localparam logic [7:0] HDR1_BYTE = 8'hf0;
    localparam logic [7:0] TRL_BYTE  = 8'h00;

    localparam logic [BIT_IDX_W-1:0] R_BIT_BASE = 5'd24;
    localparam logic [BIT_IDX_W-1:0] G_BIT_BASE = 5'd16;
    localparam logic [BIT_IDX_W-1:0] B_BIT_BASE = 5'd8;

    typedef struct packed {
        logic [COLOR_W-1:0] string0_color;
        logic [COLOR_W-1:0] string1_color;
        logic [COLOR_W-1:0] string2_color;
        logic [COLOR_W-1:0] string3_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic has_header;
        logic has_trailer;
    } t_slot_info;

endpackage

// ===== rtl/core/led_string_frame_serializer_core.sv =====
// Top level: LED string frame serializer, slot register feeding a byte output register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | i_in_valid/o_in_stall  | t_in_item, four colour words
//  out     | output    | o_out_valid/i_out_stall| t_out_item, one byte + flags
//  cfg     | input     | i_cfg_valid/o_cfg_ready| slots_per_frame, 7 bits
//
// One slot transaction yields 16 bytes, 18 with header or trailer, 20 with both,
// one byte per cycle through the output register while the output is not stalled; this sets the rate.
// The next slot is taken in the cycle its predecessor's last byte is loaded.
// Synchronous active-low reset: no slot held, slot counter 0, slots_per_frame 24.
// A stall on the output holds the output register and any slot held in the slot register.
module led_string_frame_serializer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lsfs_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lsfs_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsfs_pkg::CFG_W-1:0]         i_cfg_data
);

    lsfs_pkg::t_in_item              r_item;
    lsfs_pkg::t_slot_info            r_info;
    logic                            r_item_vld;
    logic [lsfs_pkg::BYTE_IDX_W-1:0] r_idx;
    logic                            r_out_vld;
    lsfs_pkg::t_out_item             r_out;

    lsfs_pkg::t_slot_info            in_info;
    lsfs_pkg::t_out_item             gen_out;
    logic [lsfs_pkg::BYTE_IDX_W-1:0] last_idx;
    logic                            out_free;
    logic                            load;
    logic                            item_done;
    logic                            in_acc;

    lsfs_slot_ctl u_slot_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_accept    (in_acc),
        .o_info      (in_info)
    );

    lsfs_byte_gen u_byte_gen (
        .i_item     (r_item),
        .i_info     (r_info),
        .i_idx      (r_idx),
        .o_last_idx (last_idx),
        .o_out      (gen_out)
    );

    assign out_free    = !r_out_vld || !i_out_stall;
    assign load        = r_item_vld && out_free;
    assign item_done   = load && (r_idx == last_idx);
    assign o_in_stall  = r_item_vld && !item_done;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_item_vld <= 1'b1;
            end else if (item_done) begin
                r_item_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
            r_info <= in_info;
            r_idx  <= in_info.has_header ? lsfs_pkg::IDX_HDR0 : lsfs_pkg::IDX_DATA0;
        end else if (load) begin
            r_idx <= r_idx + lsfs_pkg::BYTE_IDX_W'(1);
        end
        if (load) begin
            r_out <= gen_out;
        end
    end

endmodule

// ===== rtl/core/lsfs_slot_ctl.sv =====
// Slot counter and slots-per-frame register; flags header and trailer per slot.
module lsfs_slot_ctl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [lsfs_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                         o_cfg_ready,
    input  logic                         i_accept,
    output lsfs_pkg::t_slot_info         o_info
);

    logic [lsfs_pkg::CFG_W-1:0]      r_slots_per_frame;
    logic [lsfs_pkg::SLOT_CNT_W-1:0] r_slot_cnt;
    logic [lsfs_pkg::SLOT_CNT_W-1:0] n_slot_cnt;
    logic [lsfs_pkg::SLOT_LIM_W-1:0] limit;
    logic [lsfs_pkg::SLOT_LIM_W-1:0] cnt_plus;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_slots_per_frame == '0) begin
            limit = lsfs_pkg::SLOT_LIM_W'(1);
        end else if (32'(r_slots_per_frame) > lsfs_pkg::MAX_SLOTS) begin
            limit = lsfs_pkg::SLOT_LIM_W'(lsfs_pkg::MAX_SLOTS);
        end else begin
            limit = lsfs_pkg::SLOT_LIM_W'(r_slots_per_frame);
        end
    end

    always_comb begin
        cnt_plus           = lsfs_pkg::SLOT_LIM_W'(r_slot_cnt) + lsfs_pkg::SLOT_LIM_W'(1);
        o_info.has_header  = (r_slot_cnt == '0);
        o_info.has_trailer = (cnt_plus >= limit);
        n_slot_cnt         = o_info.has_trailer ? '0 : lsfs_pkg::SLOT_CNT_W'(cnt_plus);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_per_frame <= lsfs_pkg::CFG_W'(lsfs_pkg::CFG_RESET);
            r_slot_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_slots_per_frame <= i_cfg_data;
            end
            if (i_accept) begin
                r_slot_cnt <= n_slot_cnt;
            end
        end
    end

endmodule

// ===== rtl/core/lsfs_byte_gen.sv =====
// Byte selector: header, bit-plane data and trailer bytes of one slot by index.
module lsfs_byte_gen (
    input  lsfs_pkg::t_in_item               i_item,
    input  lsfs_pkg::t_slot_info             i_info,
    input  logic [lsfs_pkg::BYTE_IDX_W-1:0]  i_idx,
    output logic [lsfs_pkg::BYTE_IDX_W-1:0]  o_last_idx,
    output lsfs_pkg::t_out_item              o_out
);

    logic [lsfs_pkg::BYTE_IDX_W-1:0] data_idx;
    logic [2:0]                      plane;
    logic [lsfs_pkg::BIT_IDX_W-1:0]  r_bit;
    logic [lsfs_pkg::BIT_IDX_W-1:0]  g_bit;
    logic [lsfs_pkg::BIT_IDX_W-1:0]  b_bit;
    logic [3:0]                      nib_r;
    logic [3:0]                      nib_g;
    logic [3:0]                      nib_b;

    always_comb begin
        data_idx = i_idx - lsfs_pkg::IDX_DATA0;
        plane    = data_idx[3:1];
        r_bit    = lsfs_pkg::R_BIT_BASE + lsfs_pkg::BIT_IDX_W'(plane);
        g_bit    = lsfs_pkg::G_BIT_BASE + lsfs_pkg::BIT_IDX_W'(plane);
        b_bit    = lsfs_pkg::B_BIT_BASE + lsfs_pkg::BIT_IDX_W'(plane);
        nib_r    = {i_item.string0_color[r_bit], i_item.string1_color[r_bit],
                    i_item.string2_color[r_bit], i_item.string3_color[r_bit]};
        nib_g    = {i_item.string0_color[g_bit], i_item.string1_color[g_bit],
                    i_item.string2_color[g_bit], i_item.string3_color[g_bit]};
        nib_b    = {i_item.string0_color[b_bit], i_item.string1_color[b_bit],
                    i_item.string2_color[b_bit], i_item.string3_color[b_bit]};

        o_last_idx = i_info.has_trailer ? lsfs_pkg::IDX_TRL1 : lsfs_pkg::IDX_DATA_LAST;

        o_out.frame_end = 1'b0;
        case (i_idx)
            lsfs_pkg::IDX_HDR0: begin
                o_out.out_byte = lsfs_pkg::HDR0_BYTE;
            end
            lsfs_pkg::IDX_HDR1: begin
                o_out.out_byte = lsfs_pkg::HDR1_BYTE;
            end
            lsfs_pkg::IDX_TRL0: begin
                o_out.out_byte = lsfs_pkg::TRL_BYTE;
            end
            lsfs_pkg::IDX_TRL1: begin
                o_out.out_byte  = lsfs_pkg::TRL_BYTE;
                o_out.frame_end = 1'b1;
            end
            default: begin
                o_out.out_byte = data_idx[0] ? {nib_b, ~nib_b} : {nib_r, nib_g};
            end
        endcase
        o_out.run_last = (i_idx == o_last_idx);
    end

endmodule

// ===== test/led_string_frame_serializer_core_tb.sv =====
// Testbench for led_string_frame_serializer_core: random slot traffic, byte-by-byte checks.
module led_string_frame_serializer_core_tb;

    class led_byte_predictor;
        lsfs_pkg::t_out_item exp_bytes[$];
        int unsigned         slots_cfg;
        int unsigned         slot_pos;
        int unsigned         errors;

        function new();
            slots_cfg = lsfs_pkg::CFG_RESET;
            slot_pos  = 0;
            errors    = 0;
        endfunction

        function void set_slots(logic [lsfs_pkg::CFG_W-1:0] v);
            slots_cfg = v;
        endfunction

        function logic [3:0] plane_nibble(lsfs_pkg::t_in_item it, int k);
            return {it.string0_color[k], it.string1_color[k],
                    it.string2_color[k], it.string3_color[k]};
        endfunction

        function void note_slot(lsfs_pkg::t_in_item it);
            int unsigned         lim;
            logic [7:0]          seq [20];
            logic                fend [20];
            logic [3:0]          r, g, b;
            lsfs_pkg::t_out_item o;
            int                  n;
            n = 0;
            lim = (slots_cfg == 0) ? 1 :
                  (slots_cfg > lsfs_pkg::MAX_SLOTS) ? lsfs_pkg::MAX_SLOTS : slots_cfg;
            if (slot_pos == 0) begin
                seq[n] = lsfs_pkg::HDR0_BYTE; fend[n] = 1'b0; n++;
                seq[n] = lsfs_pkg::HDR1_BYTE; fend[n] = 1'b0; n++;
            end
            for (int k = 24; k < 32; k++) begin
                r = plane_nibble(it, k);
                g = plane_nibble(it, k - 8);
                b = plane_nibble(it, k - 16);
                seq[n] = {r, g};  fend[n] = 1'b0; n++;
                seq[n] = {b, ~b}; fend[n] = 1'b0; n++;
            end
            slot_pos++;
            if (slot_pos >= lim) begin
                slot_pos = 0;
                seq[n] = lsfs_pkg::TRL_BYTE; fend[n] = 1'b0; n++;
                seq[n] = lsfs_pkg::TRL_BYTE; fend[n] = 1'b1; n++;
            end
            for (int i = 0; i < n; i++) begin
                o.out_byte  = seq[i];
                o.run_last  = (i == n - 1);
                o.frame_end = fend[i];
                exp_bytes.push_back(o);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH: %s", msg);
        endtask

        task check_byte(lsfs_pkg::t_out_item got);
            lsfs_pkg::t_out_item want;
            if (exp_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
                return;
            end
            want = exp_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                          got.run_last, want.run_last, want.out_byte));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, want %b (byte %02h)",
                                          got.frame_end, want.frame_end, want.out_byte));
        endtask
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    lsfs_pkg::t_in_item         i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    lsfs_pkg::t_out_item        o_out_data;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [lsfs_pkg::CFG_W-1:0] i_cfg_data  = '0;

    led_byte_predictor  sb = new();
    bit                 quiet = 1'b0;
    int unsigned        stall_left = 0;

    led_string_frame_serializer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 15);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_byte(o_out_data);
    end

    task automatic send_slot(lsfs_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_slot(it);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.exp_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [lsfs_pkg::CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_slots(v);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic lsfs_pkg::t_in_item rand_slot();
        logic [31:0] w [4];
        for (int s = 0; s < 4; s++) begin
            case ($urandom_range(0, 5))
                0: w[s] = 32'h0;
                1: w[s] = 32'hffffffff;
                2: w[s] = 32'h1 << $urandom_range(0, 31);
                default: w[s] = $urandom;
            endcase
        end
        return {w[0], w[1], w[2], w[3]};
    endfunction

    function automatic logic [lsfs_pkg::CFG_W-1:0] pick_slots();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return 7'd65;
            5: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(2, 8));
        endcase
    endfunction

    initial begin
        int rand_items;
        int phase;
        int n;
        rand_items = 0;
        phase      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of 24, bit-plane patterns
        send_slot('0);
        send_slot('1);
        send_slot({4{32'haaaaaaaa}});
        send_slot({4{32'h55555555}});
        send_slot({32'hffffffff, 96'h0});
        send_slot({32'h0, 32'hffffffff, 64'h0});
        send_slot({64'h0, 32'hffffffff, 32'h0});
        send_slot({96'h0, 32'hffffffff});
        send_slot({32'hff000000, 32'h00ff0000, 32'h0000ff00, 32'h000000ff});

        // count lowered below slots already sent
        wait_drain();
        write_slots(7'd4);
        send_slot(rand_slot());
        for (int j = 0; j < 3; j++) send_slot(rand_slot());
        wait_drain();
        write_slots(7'd2);
        send_slot(rand_slot());

        // zero count acts as one, oversize count clamps
        wait_drain();
        write_slots(7'd0);
        send_slot(rand_slot());
        send_slot(rand_slot());
        wait_drain();
        write_slots(7'd127);
        for (int j = 0; j < 3; j++) send_slot(rand_slot());
        wait_drain();
        write_slots(7'd1);
        send_slot(rand_slot());

        // one full frame at the maximum count
        wait_drain();
        write_slots(7'd64);
        for (int j = 0; j < 64; j++) begin
            send_slot(rand_slot());
            rand_items++;
        end

        while (rand_items < 90) begin
            wait_drain();
            if (rand_items >= 70) quiet = 1'b1;
            write_slots(pick_slots());
            n = $urandom_range(4, 14);
            for (int j = 0; j < n && rand_items < 90; j++) begin
                if (phase == 1) wait_drain();
                send_slot(rand_slot());
                rand_items++;
            end
            phase++;
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_bytes.size() == 0) begin
            $display("** led_string_frame_serializer_core: PASSED **");
        end else begin
            $display("** led_string_frame_serializer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TIMEOUT");
        $display("** led_string_frame_serializer_core: FAILED **");
        $finish;
    end

endmodule
